>>> rtl/core/rsi_pkg.sv
// rsi_pkg: widths, item types and constants of the ray/sphere intersection block
// used by every module under rtl/core, no dependencies

package rsi_pkg;

  localparam int FRAC_BITS = 16;
  localparam int CW        = 32;
  localparam int DW        = FRAC_BITS + 2;
  localparam int RADW      = 31;
  localparam int MW        = CW + 1;
  localparam int PMDW      = MW + DW;
  localparam int BW        = PMDW + 2;
  localparam int SQW       = 2 * CW;
  localparam int CCW       = SQW + 3;
  localparam int R2W       = 2 * RADW;
  localparam int BMAGW     = BW - 1;
  localparam int BLW       = BMAGW / 2;
  localparam int BHW       = BMAGW - BLW;
  localparam int B2W       = 2 * BMAGW;
  localparam int SHIFT     = 2 * FRAC_BITS;
  localparam int DISCW     = B2W + 2;
  localparam int RTW       = DISCW / 2;
  localparam int RMW       = RTW + 2;
  localparam int TW        = RTW + 2;
  localparam int TDW       = TW + DW;
  localparam int SUMW      = TDW - SHIFT + 1;
  localparam int QDEPTH    = 4;
  localparam int QAW       = $clog2(QDEPTH);
  localparam int IN_TDW    = ((6 * CW + 3 * DW) + 7) / 8 * 8;
  localparam int OUT_TDW   = ((3 * CW) + 7) / 8 * 8;

  localparam logic [RADW-1:0] RADIUS_RST = RADW'(1 << FRAC_BITS);

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [DW-1:0] dir_t;

  typedef struct packed {
    coord_t [2:0]            o;
    dir_t   [2:0]            d;
    logic signed [BW-1:0]    b;
    logic signed [CCW-1:0]   c;
    logic                    miss;
  } front_item_t;

  typedef struct packed {
    coord_t [2:0]            o;
    dir_t   [2:0]            d;
    logic signed [BW-1:0]    b;
    logic                    miss;
  } side_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

>>> rtl/core/ray_sphere_intersect.sv
// ray_sphere_intersect: top level, radius register, front, queue and back
// depends on rsi_pkg, rsi_front, rsi_fifo, rsi_back
//
// Takes one ray and sphere centre per item and returns whether the ray meets the sphere
// and the first hit point, saturated, Q16.16. Items stream in and out at one per clock
// while the queue is not full and the output is not stalled; a result passes the front,
// the 4-entry queue and the back with its 53-stage square-root pipeline, and may wait in
// the queue or behind a stalled output. The user must write the radius register through
// the cfg port only while no item is in flight; the block itself does not enforce it.

module ray_sphere_intersect (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [rsi_pkg::RADW-1:0]     cfg_data_i,      // radius
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, center_x, center_y, center_z
  input  logic [rsi_pkg::IN_TDW-1:0]   s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [rsi_pkg::OUT_TDW-1:0]  m_axis_tdata,    // point_x, point_y, point_z
  output logic                         m_axis_tuser     // hit
);

  logic [rsi_pkg::RADW-1:0] radius_q;
  logic                     push, pop;
  rsi_pkg::front_item_t     f_item, q_item;
  rsi_pkg::qstat_t          q_stat;
  rsi_pkg::coord_t          point [3];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= rsi_pkg::RADIUS_RST;
    end else if (cfg_valid_i) begin
      radius_q <= cfg_data_i;
    end
  end

  rsi_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (s_axis_tdata),
    .radius_i   (radius_q),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .item_o     (f_item)
  );

  rsi_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (f_item),
    .pop_i  (pop),
    .data_o (q_item),
    .stat_o (q_stat)
  );

  rsi_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_data_i    (q_item),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .hit_o       (m_axis_tuser),
    .point_o     (point)
  );

  assign m_axis_tdata = rsi_pkg::OUT_TDW'({point[2], point[1], point[0]});

endmodule

>>> rtl/core/rsi_front.sv
// rsi_front: accepts ray items, forms m, b = m.d and c = m.m - r^2, flags early misses
// depends on rsi_pkg

module rsi_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [rsi_pkg::IN_TDW-1:0]  in_data_i,
  input  logic [rsi_pkg::RADW-1:0]    radius_i,
  input  rsi_pkg::qstat_t             q_stat_i,
  output logic                        push_o,
  output rsi_pkg::front_item_t        item_o
);

  logic en;
  logic v0_q, v1_q, v2_q;

  rsi_pkg::coord_t o_in [3];
  rsi_pkg::dir_t   d_in [3];
  rsi_pkg::coord_t c_in [3];

  rsi_pkg::coord_t o0_q [3];
  rsi_pkg::dir_t   d0_q [3];
  logic signed [rsi_pkg::MW-1:0] m0_d [3];
  logic signed [rsi_pkg::MW-1:0] m0_q [3];

  rsi_pkg::coord_t o1_q [3];
  rsi_pkg::dir_t   d1_q [3];
  logic signed [rsi_pkg::PMDW-1:0] pmd_d [3];
  logic signed [rsi_pkg::PMDW-1:0] pmd_q [3];
  logic signed [2*rsi_pkg::MW-1:0] mm_full [3];
  logic [rsi_pkg::SQW-1:0] pmm_q [3];
  logic [rsi_pkg::R2W-1:0] r2_d, r2_q;

  logic signed [rsi_pkg::BW-1:0]  b_sum;
  logic [rsi_pkg::CCW-1:0]        c_sum;
  logic signed [rsi_pkg::CCW-1:0] c_val;
  rsi_pkg::front_item_t           item_d, item_q;

  assign en         = !q_stat_i.full;
  assign in_ready_o = en;
  assign push_o     = v2_q && en;
  assign item_o     = item_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      o_in[k]    = in_data_i[k*rsi_pkg::CW +: rsi_pkg::CW];
      d_in[k]    = in_data_i[3*rsi_pkg::CW + k*rsi_pkg::DW +: rsi_pkg::DW];
      c_in[k]    = in_data_i[3*rsi_pkg::CW + 3*rsi_pkg::DW + k*rsi_pkg::CW +: rsi_pkg::CW];
      m0_d[k]    = rsi_pkg::MW'(o_in[k]) - rsi_pkg::MW'(c_in[k]);
      pmd_d[k]   = rsi_pkg::PMDW'(m0_q[k]) * rsi_pkg::PMDW'(d0_q[k]);
      mm_full[k] = (2*rsi_pkg::MW)'(m0_q[k]) * (2*rsi_pkg::MW)'(m0_q[k]);
    end
    r2_d = rsi_pkg::R2W'(radius_i) * rsi_pkg::R2W'(radius_i);
  end

  always_comb begin
    b_sum = rsi_pkg::BW'(pmd_q[0]) + rsi_pkg::BW'(pmd_q[1]) + rsi_pkg::BW'(pmd_q[2]);
    c_sum = rsi_pkg::CCW'(pmm_q[0]) + rsi_pkg::CCW'(pmm_q[1]) + rsi_pkg::CCW'(pmm_q[2])
          - rsi_pkg::CCW'(r2_q);
    c_val = $signed(c_sum);
    for (int k = 0; k < 3; k++) begin
      item_d.o[k] = o1_q[k];
      item_d.d[k] = d1_q[k];
    end
    item_d.b    = b_sum;
    item_d.c    = c_val;
    // ray starts outside and points away
    item_d.miss = !c_val[rsi_pkg::CCW-1] && (c_val != '0) &&
                  !b_sum[rsi_pkg::BW-1] && (b_sum != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        o0_q[k]  <= o_in[k];
        d0_q[k]  <= d_in[k];
        m0_q[k]  <= m0_d[k];
        o1_q[k]  <= o0_q[k];
        d1_q[k]  <= d0_q[k];
        pmd_q[k] <= pmd_d[k];
        pmm_q[k] <= mm_full[k][rsi_pkg::SQW-1:0];
      end
      r2_q   <= r2_d;
      item_q <= item_d;
    end
  end

endmodule

>>> rtl/core/rsi_fifo.sv
// rsi_fifo: short queue of classified items between front and back
// depends on rsi_pkg

module rsi_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  rsi_pkg::front_item_t  data_i,
  input  logic                  pop_i,
  output rsi_pkg::front_item_t  data_o,
  output rsi_pkg::qstat_t       stat_o
);

  rsi_pkg::front_item_t mem_q [rsi_pkg::QDEPTH];
  logic [rsi_pkg::QAW-1:0] wptr_q, rptr_q;
  logic [rsi_pkg::QAW:0]   cnt_q;

  assign stat_o.full  = (cnt_q == (rsi_pkg::QAW+1)'(rsi_pkg::QDEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign data_o       = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + 1'b1;
      if (pop_i)  rptr_q <= rptr_q + 1'b1;
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= data_i;
  end

endmodule

>>> rtl/core/rsi_isqrt.sv
// rsi_isqrt: pipelined floor square root, one result bit per stage, side data alongside
// depends on rsi_pkg

module rsi_isqrt (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [rsi_pkg::DISCW-1:0] n_i,
  input  rsi_pkg::side_t           side_i,
  output logic                     valid_o,
  output logic [rsi_pkg::RTW-1:0]  root_o,
  output rsi_pkg::side_t           side_o
);

  logic                      v_q    [rsi_pkg::RTW];
  logic [rsi_pkg::RMW-1:0]   rem_q  [rsi_pkg::RTW];
  logic [rsi_pkg::RTW-1:0]   root_q [rsi_pkg::RTW];
  logic [rsi_pkg::DISCW-1:0] n_q    [rsi_pkg::RTW];
  rsi_pkg::side_t            side_q [rsi_pkg::RTW];

  for (genvar k = 0; k < rsi_pkg::RTW; k++) begin : g_stage
    logic                      v_in;
    logic [rsi_pkg::RMW-1:0]   rem_in, rem2, test;
    logic [rsi_pkg::RTW-1:0]   root_in;
    logic [rsi_pkg::DISCW-1:0] n_in;
    rsi_pkg::side_t            side_in;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign n_in    = n_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign n_in    = n_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign rem2 = {rem_in[rsi_pkg::RMW-3:0], n_in[rsi_pkg::DISCW-1 -: 2]};
    assign test = {root_in, 2'b01};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem2 >= test) begin
          rem_q[k]  <= rem2 - test;
          root_q[k] <= {root_in[rsi_pkg::RTW-2:0], 1'b1};
        end else begin
          rem_q[k]  <= rem2;
          root_q[k] <= {root_in[rsi_pkg::RTW-2:0], 1'b0};
        end
        n_q[k]    <= {n_in[rsi_pkg::DISCW-3:0], 2'b00};
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = v_q[rsi_pkg::RTW-1];
  assign root_o  = root_q[rsi_pkg::RTW-1];
  assign side_o  = side_q[rsi_pkg::RTW-1];

endmodule

>>> rtl/core/rsi_back.sv
// rsi_back: discriminant, root, distance and saturated hit point with the output register
// depends on rsi_pkg and rsi_isqrt

module rsi_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rsi_pkg::front_item_t  q_data_i,
  input  rsi_pkg::qstat_t       q_stat_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  hit_o,
  output rsi_pkg::coord_t       point_o [3]
);

  logic en;
  logic va_q, vb_q, vc_q, vd_q;

  logic [rsi_pkg::BMAGW-1:0]         bmag;
  logic [rsi_pkg::BHW-1:0]           bh;
  logic [rsi_pkg::BLW-1:0]           bl;
  logic [2*rsi_pkg::BHW-1:0]         hh_q;
  logic [rsi_pkg::BHW+rsi_pkg::BLW-1:0] hl_q;
  logic [2*rsi_pkg::BLW-1:0]         ll_q;
  rsi_pkg::front_item_t              ita_q;

  logic [rsi_pkg::B2W-1:0]           b2;
  logic signed [rsi_pkg::DISCW-1:0]  cs, disc;
  logic [rsi_pkg::DISCW-1:0]         n_in;
  rsi_pkg::side_t                    side_in;

  logic                              sq_valid;
  logic [rsi_pkg::RTW-1:0]           root;
  rsi_pkg::side_t                    sq_side;

  logic signed [rsi_pkg::TW-1:0]     t_full, tc_q;
  rsi_pkg::side_t                    sc_q, sd_q;
  logic signed [rsi_pkg::TDW-1:0]    prod_d [3];
  logic signed [rsi_pkg::TDW-1:0]    prod_q [3];
  logic signed [rsi_pkg::SUMW-1:0]   psum [3];
  rsi_pkg::coord_t                   psat [3];
  rsi_pkg::coord_t                   pt_q [3];
  logic                              hit_q;

  assign en          = !vd_q || out_ready_i;
  assign pop_o       = en && !q_stat_i.empty;
  assign out_valid_o = vd_q;
  assign hit_o       = hit_q;

  always_comb begin
    bmag = q_data_i.b[rsi_pkg::BW-1] ? rsi_pkg::BMAGW'(-q_data_i.b)
                                      : rsi_pkg::BMAGW'(q_data_i.b);
    bh   = bmag[rsi_pkg::BMAGW-1:rsi_pkg::BLW];
    bl   = bmag[rsi_pkg::BLW-1:0];
  end

  // b squared from the partial products, then b^2 - c scaled to the same point
  always_comb begin
    b2 = (rsi_pkg::B2W'(hh_q) << (2*rsi_pkg::BLW))
       + (rsi_pkg::B2W'(hl_q) << (rsi_pkg::BLW+1))
       + rsi_pkg::B2W'(ll_q);
    cs   = rsi_pkg::DISCW'(ita_q.c) <<< rsi_pkg::SHIFT;
    disc = $signed(rsi_pkg::DISCW'(b2)) - cs;
    side_in.o    = ita_q.o;
    side_in.d    = ita_q.d;
    side_in.b    = ita_q.b;
    side_in.miss = ita_q.miss || disc[rsi_pkg::DISCW-1];
    n_in         = side_in.miss ? '0 : disc;
  end

  rsi_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (va_q),
    .n_i     (n_in),
    .side_i  (side_in),
    .valid_o (sq_valid),
    .root_o  (root),
    .side_o  (sq_side)
  );

  always_comb begin
    t_full = -rsi_pkg::TW'(sq_side.b) - $signed(rsi_pkg::TW'(root));
    for (int k = 0; k < 3; k++) begin
      prod_d[k] = rsi_pkg::TDW'(tc_q) * rsi_pkg::TDW'($signed(sc_q.d[k]));
      psum[k]   = rsi_pkg::SUMW'($signed(sd_q.o[k]))
                + rsi_pkg::SUMW'($signed(prod_q[k][rsi_pkg::TDW-1:rsi_pkg::SHIFT]));
      if (&psum[k][rsi_pkg::SUMW-1:rsi_pkg::CW-1] ||
          ~|psum[k][rsi_pkg::SUMW-1:rsi_pkg::CW-1]) begin
        psat[k] = psum[k][rsi_pkg::CW-1:0];
      end else if (psum[k][rsi_pkg::SUMW-1]) begin
        psat[k] = {1'b1, {(rsi_pkg::CW-1){1'b0}}};
      end else begin
        psat[k] = {1'b0, {(rsi_pkg::CW-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else if (en) begin
      va_q <= !q_stat_i.empty;
      vb_q <= sq_valid;
      vc_q <= vb_q;
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hh_q  <= (2*rsi_pkg::BHW)'(bh) * (2*rsi_pkg::BHW)'(bh);
      hl_q  <= (rsi_pkg::BHW+rsi_pkg::BLW)'(bh) * (rsi_pkg::BHW+rsi_pkg::BLW)'(bl);
      ll_q  <= (2*rsi_pkg::BLW)'(bl) * (2*rsi_pkg::BLW)'(bl);
      ita_q <= q_data_i;
      tc_q  <= t_full[rsi_pkg::TW-1] ? '0 : t_full;
      sc_q  <= sq_side;
      sd_q  <= sc_q;
      hit_q <= !sd_q.miss;
      for (int k = 0; k < 3; k++) begin
        prod_q[k] <= prod_d[k];
        pt_q[k]   <= sd_q.miss ? '0 : psat[k];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) point_o[k] = pt_q[k];
  end

endmodule

>>> rtl/core/rsi_checker.sv
// rsi_checker: port-level assertions for ray_sphere_intersect, bound to the top level
// depends on rsi_pkg

module rsi_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         cfg_ready_o,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [rsi_pkg::OUT_TDW-1:0]  m_axis_tdata,
  input logic                         m_axis_tuser
);

  // a miss carries a zero point
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("miss item with nonzero point");

  // nothing comes out while in reset
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid)
    else $error("output valid during reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled output item changed");

  // the radius register always takes a write
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("cfg port not ready");

endmodule

bind ray_sphere_intersect rsi_checker u_rsi_checker (.*);
